// ===== rtl/core/event_queue_with_storm_drop_defines.svh =====
// Assertion macros for the event queue with storm drop.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef EVENT_QUEUE_WITH_STORM_DROP_DEFINES_SVH
`define EVENT_QUEUE_WITH_STORM_DROP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EQSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EQSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/eqsd_pkg.sv =====
// Package for the event queue with storm drop: sizes, config codes and the
// command record passed from the front stage to the back stage. No dependencies.
`timescale 1ns / 1ps

package eqsd_pkg;

    localparam int DEPTH         = 1024;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int FILL_BITS     = $clog2(DEPTH + 1);
    localparam int TYPE_BITS     = 8;
    localparam int PAYLOAD_BITS  = 32;
    localparam int ENTRY_BITS    = TYPE_BITS + PAYLOAD_BITS;

    localparam int QLIMIT_BITS   = 11;
    localparam int THRESH_BITS   = 16;
    localparam int RUN_BITS      = 16;
    localparam int DROP_BITS     = 32;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_QUEUE_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_LIMIT = 2'd1;

    localparam logic [QLIMIT_BITS-1:0] QLIMIT_RESET = 11'd1024;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd100;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Command queue between the stages
    localparam int QDEPTH     = 2;
    localparam int Q_PTR_BITS = $clog2(QDEPTH);
    localparam int Q_CNT_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                  wr;        // store entry, result reports accepted
        logic                  rd;        // fetch entry, result reports a dequeue
        logic [ADDR_BITS-1:0]  addr;
        logic [ENTRY_BITS-1:0] entry;     // {type, payload}
        logic [FILL_BITS-1:0]  occupancy;
        logic [DROP_BITS-1:0]  dropped;
    } cmd_t;

endpackage

// ===== rtl/core/eqsd_front.sv =====
// Front stage: accepts items, runs admission control and owns the storage pointers and
// counters. Emits one cmd_t per input transfer, dropped items included. Depends on eqsd_pkg.
`timescale 1ns / 1ps

module eqsd_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic [eqsd_pkg::TYPE_BITS-1:0]     event_type,
    input  logic [eqsd_pkg::PAYLOAD_BITS-1:0]  payload,
    input  logic                               cfg_we,
    input  logic [eqsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [eqsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic                               push_valid,
    input  logic                               push_ready,
    output eqsd_pkg::cmd_t                     push_data
);
    import eqsd_pkg::*;

    logic [ADDR_BITS-1:0]   head_reg, head_next;
    logic [ADDR_BITS-1:0]   tail_reg, tail_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [TYPE_BITS-1:0]   last_type_reg, last_type_next;
    logic [RUN_BITS-1:0]    run_reg, run_next;
    logic [DROP_BITS-1:0]   drop_reg, drop_next;
    logic [QLIMIT_BITS-1:0] queue_limit_reg;
    logic [THRESH_BITS-1:0] threshold_reg;
    logic                   take;
    logic                   drop;

    assign in_stall   = !push_ready;
    assign push_valid = in_valid;
    assign take       = in_valid && push_ready;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        last_type_next = last_type_reg;
        run_next       = run_reg;
        drop_next      = drop_reg;
        drop           = 1'b0;
        push_data      = '0;
        push_data.entry = {event_type, payload};

        if (opcode == OP_ENQUEUE)
        begin
            if (event_type == last_type_reg)
            begin
                if (run_reg != '1)
                    run_next = run_reg + 1'b1;
            end
            else
            begin
                run_next       = RUN_BITS'(1);
                last_type_next = event_type;
            end

            if (32'(fill_reg) >= 32'(queue_limit_reg))
            begin
                if (event_type == '0 || run_next >= threshold_reg)
                    drop = 1'b1;
            end
            if (fill_reg == FILL_BITS'(DEPTH))
                drop = 1'b1;

            if (drop)
            begin
                if (drop_reg != '1)
                    drop_next = drop_reg + 1'b1;
            end
            else
            begin
                push_data.wr   = 1'b1;
                push_data.addr = tail_reg;
                tail_next = (tail_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (fill_reg != '0)
        begin
            push_data.rd   = 1'b1;
            push_data.addr = head_reg;
            head_next = (head_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end

        push_data.occupancy = fill_next;
        push_data.dropped   = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            last_type_reg <= '0;
            run_reg       <= '0;
            drop_reg      <= '0;
        end
        else if (take)
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            last_type_reg <= last_type_next;
            run_reg       <= run_next;
            drop_reg      <= drop_next;
        end
    end

    // Register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= QLIMIT_RESET;
            threshold_reg   <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUEUE_LIMIT:     queue_limit_reg <= cfg_data[QLIMIT_BITS-1:0];
                REG_THRESHOLD_LIMIT: threshold_reg   <= cfg_data[THRESH_BITS-1:0];
                default:             ;
            endcase
        end
    end

endmodule

// ===== rtl/core/eqsd_cmd_queue.sv =====
// Small command queue that decouples the front and back stages.
// Circular buffer of QDEPTH cmd_t entries. Depends on eqsd_pkg.
`timescale 1ns / 1ps

module eqsd_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  eqsd_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output eqsd_pkg::cmd_t pop_data
);
    import eqsd_pkg::*;

    cmd_t                  slot_reg [QDEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != Q_CNT_BITS'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/eqsd_back.sv =====
// Back stage: event storage access and the result register.
// At most one storage write or read per command. Depends on eqsd_pkg.
`timescale 1ns / 1ps

module eqsd_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  eqsd_pkg::cmd_t                    pop_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              dequeue_valid,
    output logic [eqsd_pkg::TYPE_BITS-1:0]    out_event_type,
    output logic [eqsd_pkg::PAYLOAD_BITS-1:0] out_payload,
    output logic [eqsd_pkg::FILL_BITS-1:0]    occupancy,
    output logic [eqsd_pkg::DROP_BITS-1:0]    dropped_total
);
    import eqsd_pkg::*;

    logic [ENTRY_BITS-1:0] store [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg;
    logic                  acc_reg;
    logic                  dv_reg;
    logic [FILL_BITS-1:0]  occ_reg;
    logic [DROP_BITS-1:0]  drop_reg;
    logic                  issue;

    // Result slot frees up when empty or being taken this cycle
    assign pop_ready = !out_valid_reg || !out_stall;
    assign issue     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop_ready)
            out_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            acc_reg  <= pop_data.wr;
            dv_reg   <= pop_data.rd;
            occ_reg  <= pop_data.occupancy;
            drop_reg <= pop_data.dropped;
            if (pop_data.wr)
                store[pop_data.addr] <= pop_data.entry;
            if (pop_data.rd)
                rd_data_reg <= store[pop_data.addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_reg;
    assign dequeue_valid  = dv_reg;
    assign out_event_type = dv_reg ? rd_data_reg[ENTRY_BITS-1 -: TYPE_BITS] : '0;
    assign out_payload    = dv_reg ? rd_data_reg[PAYLOAD_BITS-1:0] : '0;
    assign occupancy      = occ_reg;
    assign dropped_total  = drop_reg;

endmodule

// ===== rtl/core/event_queue_with_storm_drop.sv =====
// Event queue with storm drop: FIFO of typed events with admission control.
// Instantiates eqsd_front, eqsd_cmd_queue and eqsd_back; uses eqsd_pkg and
// the assertion macros in event_queue_with_storm_drop_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 enqueues {event_type, payload},
//   opcode 1 dequeues the oldest event. Every input transfer yields exactly one
//   result transfer on the output channel (out_valid / out_stall), in order.
//   Config channel (cfg_valid / cfg_ready): index 0 queue_limit, index 1
//   threshold_limit; cfg_ready is always high, other indexes are ignored.
//   Write config only while the block is idle.
// Each command is registered first in the command queue, then in the result register.
// Throughput: one item per cycle while out_stall is low, set by the single storage port
//   of the back stage, which does one write or one read per cycle.
// Admission decisions, pointers and counters resolve in the front stage in
//   the cycle of transfer; a two-entry command queue feeds the back stage.
// Reset: queue empty, run tracker and drop count cleared, queue_limit = 1024,
//   threshold_limit = 100. Storage contents are not cleared.
// Output stall: the result register holds; the command queue absorbs up to two
//   more items, then in_stall rises until the receiver drains.
`timescale 1ns / 1ps

module event_queue_with_storm_drop
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic [eqsd_pkg::TYPE_BITS-1:0]     event_type,
    input  logic [eqsd_pkg::PAYLOAD_BITS-1:0]  payload,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               dequeue_valid,
    output logic [eqsd_pkg::TYPE_BITS-1:0]     out_event_type,
    output logic [eqsd_pkg::PAYLOAD_BITS-1:0]  out_payload,
    output logic [eqsd_pkg::FILL_BITS-1:0]     occupancy,
    output logic [eqsd_pkg::DROP_BITS-1:0]     dropped_total,
    // config channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [eqsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [eqsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import eqsd_pkg::*;

    `include "event_queue_with_storm_drop_defines.svh"

    logic cfg_we;
    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    // Registers are plain flops, so writes never wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Classification and bookkeeping; one command per input transfer
    eqsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .event_type (event_type),
        .payload    (payload),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue: front keeps accepting while results wait
    eqsd_cmd_queue u_cmd_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Storage access and result register
    eqsd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .dequeue_valid  (dequeue_valid),
        .out_event_type (out_event_type),
        .out_payload    (out_payload),
        .occupancy      (occupancy),
        .dropped_total  (dropped_total)
    );

    // A result is never both a stored enqueue and a dequeue
    `EQSD_ASSERT_NOW(a_acc_dv_excl, out_valid, !(accepted && dequeue_valid), "accepted and dequeue_valid both set")

    // No dequeued event means zeroed event fields
    `EQSD_ASSERT_NOW(a_empty_fields, out_valid && !dequeue_valid, out_event_type == '0 && out_payload == '0, "event fields nonzero without a dequeue")

    // Occupancy never exceeds storage
    `EQSD_ASSERT_NOW(a_occ_bound, out_valid, occupancy <= FILL_BITS'(DEPTH), "occupancy above storage depth")

    // Drop count only grows between consecutive results
    `EQSD_ASSERT_NEXT(a_drop_mono, out_valid && !out_stall && in_valid && !in_stall, !out_valid || dropped_total >= $past(dropped_total), "drop count decreased")

endmodule
